### rtl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and constants for the two-stack queue: sizes, status and
// operation codes, and the command word passed from front to back.
// ----------------------------------------------------------------------------
package qts_pkg;

   localparam int DEPTH  = 128;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SLOTS  = 2 * DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int TOT_W  = ADDR_W + 1;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [TOT_W-1:0]         tot_type;
   typedef logic [QPTR_W-1:0]        qptr_type;
   typedef logic [QCNT_W-1:0]        qcnt_type;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam cnt_type  CNT_FULL  = CNT_W'(DEPTH);
   localparam addr_type ADDR_LAST = ADDR_W'(SLOTS - 1);
   localparam tot_type  TOT_SLOTS = TOT_W'(SLOTS);
   localparam qptr_type QPTR_LAST = QPTR_W'(QDEPTH - 1);
   localparam qcnt_type QCNT_FULL = QCNT_W'(QDEPTH);

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
      addr_type   addr;
      word_type   data;
   } cmd_type;

endpackage

### rtl/qts_front.sv
// ----------------------------------------------------------------------------
// qts_front
// Accepts requests and classifies them against the two stack counts.
// Both stacks live in one circular buffer; a transfer is a count move.
// ----------------------------------------------------------------------------
module qts_front
   import qts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_action,
   input  word_type req_push_value,
   input  logic     q_full,
   output logic     cmd_valid,
   output cmd_type  cmd
);

   cnt_type  in_cnt_ff, in_cnt_in;
   cnt_type  out_cnt_ff, out_cnt_in;
   addr_type head_ff, head_in;
   addr_type tail_ff, tail_in;
   logic     accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cmd_valid = accept;

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cmd.op     = OP_NONE;
      cmd.status = ST_DONE;
      cmd.addr   = tail_ff;
      cmd.data   = req_push_value;
      if (!req_action) begin
         if (in_cnt_ff != CNT_FULL) begin
            cmd.op    = OP_WRITE;
            in_cnt_in = in_cnt_ff + 1'b1;
         end else if (out_cnt_ff == '0) begin
            cmd.op     = OP_WRITE;
            out_cnt_in = CNT_FULL;
            in_cnt_in  = CNT_W'(1);
         end else begin
            cmd.status = ST_FULL;
         end
         if (cmd.op == OP_WRITE) begin
            tail_in = (tail_ff == ADDR_LAST) ? '0 : tail_ff + 1'b1;
         end
      end else begin
         cmd.addr = head_ff;
         if (out_cnt_ff != '0) begin
            cmd.op     = OP_READ;
            out_cnt_in = out_cnt_ff - 1'b1;
         end else if (in_cnt_ff != '0) begin
            cmd.op     = OP_READ;
            out_cnt_in = in_cnt_ff - 1'b1;
            in_cnt_in  = '0;
         end else begin
            cmd.status = ST_EMPTY;
         end
         if (cmd.op == OP_READ) begin
            head_in = (head_ff == ADDR_LAST) ? '0 : head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else if (accept) begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   // occupancy of the ring must match the two stack counts
   tot_type occ;
   tot_type total;

   assign occ   = (tail_ff >= head_ff) ?
                  (TOT_W'(tail_ff) - TOT_W'(head_ff)) :
                  (TOT_W'(tail_ff) + TOT_SLOTS - TOT_W'(head_ff));
   assign total = TOT_W'(in_cnt_ff) + TOT_W'(out_cnt_ff);

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (in_cnt_ff <= CNT_FULL) && (out_cnt_ff <= CNT_FULL))
      else $error("stack count above depth");

   a_ring_matches: assert property (@(posedge clock) disable iff (reset)
      (total == occ) || (total == TOT_SLOTS && occ == '0))
      else $error("ring occupancy differs from stack counts");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.status != ST_DONE |=>
         $stable(in_cnt_ff) && $stable(out_cnt_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("refused request changed state");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.status == ST_FULL |-> in_cnt_ff == CNT_FULL && out_cnt_ff != '0)
      else $error("push refused with room left");

endmodule

### rtl/qts_cmd_queue.sv
// ----------------------------------------------------------------------------
// qts_cmd_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module qts_cmd_queue
   import qts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_take,
   output cmd_type pop_cmd
);

   cmd_type  entry_ff [QDEPTH];
   qptr_type wr_ptr_ff;
   qptr_type rd_ptr_ff;
   qcnt_type cnt_ff;
   logic     do_push;
   logic     do_pop;

   assign full      = (cnt_ff == QCNT_FULL);
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_take && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/qts_back.sv
// ----------------------------------------------------------------------------
// qts_back
// Executes commands against the shared ring memory and drives the result
// register. One memory access per cycle when not stalled; registered read.
// ----------------------------------------------------------------------------
module qts_back
   import qts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic signed [31:0] rsp_pop_value
);

   word_type   mem [SLOTS];
   word_type   rd_ff;
   logic       p_valid_ff;
   status_type p_status_ff;
   logic       p_read_ff;
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   word_type   rsp_value_ff;
   logic       p_adv;
   logic       issue;

   assign p_adv    = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue    = cmd_valid && (!p_valid_ff || p_adv);
   assign cmd_take = issue;

   always_ff @(posedge clock) begin
      if (issue && cmd.op == OP_WRITE) begin
         mem[cmd.addr] <= cmd.data;
      end
      if (issue && cmd.op == OP_READ) begin
         rd_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_status_ff <= cmd.status;
         p_read_ff   <= (cmd.op == OP_READ);
      end
      if (p_adv) begin
         rsp_status_ff <= p_status_ff;
         rsp_value_ff  <= p_read_ff ? rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            p_valid_ff <= 1'b1;
         end else if (p_adv) begin
            p_valid_ff <= 1'b0;
         end
         if (p_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_value_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !p_adv)
      else $error("stalled result overwritten");

   a_read_only_done: assert property (@(posedge clock) disable iff (reset)
      issue && cmd.op != OP_NONE |-> cmd.status == ST_DONE)
      else $error("memory access on refused command");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      p_adv && !p_read_ff |=> rsp_value_ff == '0)
      else $error("nonzero value on non-pop result");

endmodule

### rtl/queue_from_two_stacks.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// FIFO of signed 32-bit words behaving as a queue built from two stacks of
// DEPTH words each (an inbound and an outbound stack).
//
// Request channel (req_*): action 0 pushes req_push_value, action 1 pops the
// oldest word. A request is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): exactly one response per request, in request order.
// rsp_status is done, full (push refused) or empty (pop refused);
// rsp_pop_value holds the popped word on a successful pop, else zero.
// A push is refused only when the inbound stack is full and the outbound
// stack still holds words.
// Both stacks share one ring memory of 2*DEPTH words; moving the inbound
// stack across is a count update, so no request ever waits for a transfer.
// The response passes the command queue, the back stage and the result register.
// One request per cycle while rsp_stall is low, bounded by the single memory port.
// Reset clears both counts and the ring pointers; memory is not cleared.
// When the receiver stalls, the response holds, one more result waits in
// the back stage, and the two-entry command queue then fills and raises
// req_stall.
// ----------------------------------------------------------------------------
module queue_from_two_stacks
   import qts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_pop_value
);

   logic    f_valid;
   cmd_type f_cmd;
   logic    q_full;
   logic    q_valid;
   logic    q_take;
   cmd_type q_cmd;

   qts_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .q_full         (q_full),
      .cmd_valid      (f_valid),
      .cmd            (f_cmd)
   );

   qts_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_cmd   (f_cmd),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_take   (q_take),
      .pop_cmd    (q_cmd)
   );

   qts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd           (q_cmd),
      .cmd_take      (q_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_pop_value (rsp_pop_value)
   );

endmodule
